// ----- rtl/core/recursive_lock_table_top_assert.svh -----
// ----------------------------------------------------------------------------
// recursive lock table assertion macros
// shared property wrappers for the lock table checks
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_LOCK_TABLE_TOP_ASSERT_SVH
`define RECURSIVE_LOCK_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define RLT_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("lock table check failed");

// next-cycle implication, sampled on the rising clock edge
`define RLT_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("lock table check failed");

`endif

// ----- rtl/core/rlt_pkg.sv -----
// ----------------------------------------------------------------------------
// rlt_pkg
// types and constants shared by the recursive lock table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlt_pkg;

  // fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned STATUS_W = 3;

  // number of locks the index field can name
  localparam int unsigned IDX_SPAN = 1 << IDX_W;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE     = 3'd0,
    OP_REACQUIRE   = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_RELEASE_ALL = 3'd3,
    OP_QUERY       = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_ILLEGAL   = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // outcome of one request against one table entry
  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   hold;
    logic                 we;
    logic                 own_valid;
    logic [COUNT_W-1:0]   count;
  } exec_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/rlt_mem.sv -----
// ----------------------------------------------------------------------------
// rlt_mem
// entry storage: owner thread and hold count, one write and one read port,
// registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlt_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 48
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/rlt_exec.sv -----
// ----------------------------------------------------------------------------
// rlt_exec
// applies one request to the current contents of one lock entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlt_exec #(
  parameter int unsigned THREAD_BITS = 16
) (
  input  wire rlt_pkg::op_e                    op_i,
  input  wire logic                            in_range_i,
  input  wire logic                            cur_valid_i,
  input  wire logic [THREAD_BITS-1:0]          cur_thread_i,
  input  wire logic [rlt_pkg::COUNT_W-1:0]     cur_count_i,
  input  wire logic [THREAD_BITS-1:0]          tid_i,
  input  wire logic [rlt_pkg::COUNT_W-1:0]     count_value_i,
  output rlt_pkg::exec_res_t                   res_o
);

  logic mine;
  logic count_zero;
  logic count_max;

  assign mine       = cur_valid_i && (cur_thread_i == tid_i);
  assign count_zero = (cur_count_i == '0);
  assign count_max  = (cur_count_i == '1);

  // per-operation outcome
  always_comb begin
    res_o           = '0;
    res_o.status    = rlt_pkg::ST_OK;
    res_o.own_valid = cur_valid_i;
    res_o.count     = cur_count_i;
    if (!in_range_i) begin
      unique case (op_i)
        rlt_pkg::OP_ACQUIRE, rlt_pkg::OP_REACQUIRE, rlt_pkg::OP_RELEASE,
        rlt_pkg::OP_RELEASE_ALL, rlt_pkg::OP_QUERY: begin
          res_o.status = rlt_pkg::ST_NOT_OWNER;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (op_i)
        rlt_pkg::OP_ACQUIRE: begin
          if (!cur_valid_i) begin
            res_o.we        = 1'b1;
            res_o.own_valid = 1'b1;
            res_o.count     = rlt_pkg::COUNT_W'(1);
          end else if (mine) begin
            if (count_max) begin
              res_o.status = rlt_pkg::ST_OVERFLOW;
            end else begin
              res_o.we    = 1'b1;
              res_o.count = cur_count_i + rlt_pkg::COUNT_W'(1);
            end
          end else begin
            res_o.status = rlt_pkg::ST_BUSY;
          end
        end
        rlt_pkg::OP_REACQUIRE: begin
          if (!cur_valid_i) begin
            res_o.we        = 1'b1;
            res_o.own_valid = 1'b1;
            res_o.count     = count_value_i;
          end else if (mine) begin
            res_o.status = rlt_pkg::ST_ILLEGAL;
          end else begin
            res_o.status = rlt_pkg::ST_BUSY;
          end
        end
        rlt_pkg::OP_RELEASE: begin
          if (!mine || count_zero) begin
            res_o.status = rlt_pkg::ST_NOT_OWNER;
          end else begin
            res_o.we        = 1'b1;
            res_o.count     = cur_count_i - rlt_pkg::COUNT_W'(1);
            res_o.own_valid = (cur_count_i != rlt_pkg::COUNT_W'(1));
          end
        end
        rlt_pkg::OP_RELEASE_ALL: begin
          if (!mine || count_zero) begin
            res_o.status = rlt_pkg::ST_NOT_OWNER;
          end else begin
            res_o.hold      = cur_count_i;
            res_o.we        = 1'b1;
            res_o.own_valid = 1'b0;
            res_o.count     = '0;
          end
        end
        rlt_pkg::OP_QUERY: begin
          if (mine) begin
            res_o.hold = cur_count_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/recursive_lock_table_top.sv -----
// ----------------------------------------------------------------------------
// recursive_lock_table_top
// table of recursive locks with owner thread and hold count per entry
// ----------------------------------------------------------------------------
// One item enters per cycle while the input is not stalled: the first stage
// reads the entry from the table memory, the second applies the
// operation, writes the entry back and loads the output register. Items to
// the same lock may follow each other back to back, the written entry is
// forwarded to the next read. The held flags live in flip-flops cleared by
// reset, so there is no clearing pass and the block takes items right after
// reset. Input stall rises only while stage two is full and the output is
// stalled.
`timescale 1ns / 1ps
`default_nettype none

`include "recursive_lock_table_top_assert.svh"

module recursive_lock_table_top #(
  parameter int unsigned LOCK_ENTRIES = 64,
  parameter int unsigned THREAD_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rlt_pkg::OP_W-1:0]      operation_i,
  input  wire logic [rlt_pkg::IDX_W-1:0]     lock_index_i,
  input  wire logic [rlt_pkg::TID_W-1:0]     thread_id_i,
  input  wire logic [rlt_pkg::COUNT_W-1:0]   count_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rlt_pkg::STATUS_W-1:0]       status_o,
  output logic [rlt_pkg::COUNT_W-1:0]        hold_count_o
);

  localparam int unsigned MEM_DEPTH =
    (LOCK_ENTRIES < rlt_pkg::IDX_SPAN) ? LOCK_ENTRIES : rlt_pkg::IDX_SPAN;
  localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned DATA_W = THREAD_BITS + rlt_pkg::COUNT_W;
  localparam int unsigned LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT = LIMIT_W'(LOCK_ENTRIES);

  // input side
  logic                         accept;
  logic                         in_range;
  logic [ADDR_W-1:0]            in_addr;
  logic [31:0]                  tid_ext;
  logic [THREAD_BITS-1:0]       tid_in;

  // stage two registers
  logic                         s1_valid_q, s1_valid_d;
  rlt_pkg::op_e                 s1_op_q;
  logic                         s1_in_range_q;
  logic [ADDR_W-1:0]            s1_addr_q;
  logic [THREAD_BITS-1:0]       s1_tid_q;
  logic [rlt_pkg::COUNT_W-1:0]  s1_cnt_q;
  logic                         s1_adv;

  // forwarding of the entry written in the cycle of a read
  logic                         fwd_hit_q, fwd_hit_d;
  logic [DATA_W-1:0]            fwd_data_q;

  // held flags, one per entry
  logic [MEM_DEPTH-1:0]         held_q;

  // entry data
  logic [DATA_W-1:0]            rdata;
  logic [DATA_W-1:0]            cur_data;
  logic [DATA_W-1:0]            wdata;
  logic [THREAD_BITS-1:0]       wr_thread;
  logic                         cur_valid;
  logic                         mem_we;
  rlt_pkg::exec_res_t           res;

  // output register
  logic                         out_valid_q, out_valid_d;
  rlt_pkg::status_e             status_q;
  logic [rlt_pkg::COUNT_W-1:0]  hold_q;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // request decode
  assign tid_ext  = {{(32 - rlt_pkg::TID_W){1'b0}}, thread_id_i};
  assign tid_in   = tid_ext[THREAD_BITS-1:0];
  assign in_range = ({{(LIMIT_W - rlt_pkg::IDX_W){1'b0}}, lock_index_i} < ENTRY_LIMIT);
  assign in_addr  = lock_index_i[ADDR_W-1:0];

  // entry storage
  rlt_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_addr_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // current entry, forwarded when the previous item wrote it
  assign cur_data  = fwd_hit_q ? fwd_data_q : rdata;
  assign cur_valid = s1_in_range_q ? held_q[s1_addr_q] : 1'b0;

  rlt_exec #(
    .THREAD_BITS (THREAD_BITS)
  ) u_exec (
    .op_i          (s1_op_q),
    .in_range_i    (s1_in_range_q),
    .cur_valid_i   (cur_valid),
    .cur_thread_i  (cur_data[DATA_W-1:rlt_pkg::COUNT_W]),
    .cur_count_i   (cur_data[rlt_pkg::COUNT_W-1:0]),
    .tid_i         (s1_tid_q),
    .count_value_i (s1_cnt_q),
    .res_o         (res)
  );

  // write back
  assign mem_we    = s1_adv && res.we;
  assign wr_thread = res.own_valid ? s1_tid_q : '0;
  assign wdata     = {wr_thread, res.count};

  // control next values
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    fwd_hit_d = fwd_hit_q;
    if (accept) begin
      fwd_hit_d = mem_we && in_range && (s1_addr_q == in_addr);
    end else if (s1_adv) begin
      fwd_hit_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        held_q[s1_addr_q] <= res.own_valid;
      end
    end
  end

  // stage two payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= rlt_pkg::op_e'(operation_i);
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
      s1_tid_q      <= tid_in;
      s1_cnt_q      <= count_value_i;
      fwd_data_q    <= wdata;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q <= res.status;
      hold_q   <= res.hold;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign hold_count_o = hold_q;

  // checks
  `RLT_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q && out_stall_i)
  `RLT_ASSERT_IMP(a_fwd_needs_item, clk_i, rst_ni, fwd_hit_q, s1_valid_q)
  `RLT_ASSERT_IMP(a_no_write_out_of_range, clk_i, rst_ni, s1_valid_q && !s1_in_range_q, !res.we)
  `RLT_ASSERT_NXT(a_free_acquire_ok, clk_i, rst_ni, s1_adv && s1_in_range_q && !cur_valid && (s1_op_q == rlt_pkg::OP_ACQUIRE), out_valid_o && (status_o == rlt_pkg::ST_OK))

endmodule

`default_nettype wire

// ----- test/tb_recursive_lock_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_recursive_lock_table_top
// self-checking bench for the recursive lock table: a short table of directed
// requests, most with fixed results, then random traffic idling on both sides,
// all checked in order, the rest against a cycle-free model of the lock table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_recursive_lock_table_top;

  // operation codes the block treats as no-ops
  localparam logic [rlt_pkg::OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [rlt_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam int unsigned LOCKS         = 64;
  localparam int unsigned RANDOM_ITEMS  = 225;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned WATCHDOG_MAX  = 5000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam bit          TYPED         = 1'b1;
  localparam bit          MODELED       = 1'b0;

  typedef struct packed {
    logic [rlt_pkg::OP_W-1:0]    op;
    logic [rlt_pkg::IDX_W-1:0]   idx;
    logic [rlt_pkg::TID_W-1:0]   tid;
    logic [rlt_pkg::COUNT_W-1:0] cnt;
  } lock_request_t;

  typedef struct packed {
    rlt_pkg::status_e            status;
    logic [rlt_pkg::COUNT_W-1:0] hold;
  } lock_result_t;

  typedef struct packed {
    lock_request_t req;
    bit            typed;
    lock_result_t  res;
  } stim_row_t;

  // clock, reset and block ports
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic [rlt_pkg::OP_W-1:0]     operation_i   = '0;
  logic [rlt_pkg::IDX_W-1:0]    lock_index_i  = '0;
  logic [rlt_pkg::TID_W-1:0]    thread_id_i   = '0;
  logic [rlt_pkg::COUNT_W-1:0]  count_value_i = '0;
  logic                         out_stall_i   = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [rlt_pkg::STATUS_W-1:0] status_o;
  logic [rlt_pkg::COUNT_W-1:0]  hold_count_o;

  // model of the lock table
  logic                        tbl_held  [LOCKS];
  logic [rlt_pkg::TID_W-1:0]   tbl_owner [LOCKS];
  logic [rlt_pkg::COUNT_W-1:0] tbl_count [LOCKS];

  lock_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  stim_row_t    cur_row;

  // phase control, set by the sequencer on the falling edge, and check counters
  int           to_issue     = 0;
  bit           from_table   = 1'b0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  logic [5:0]   hot_mask     = '0;
  logic [15:0]  tid_pool [4];
  int           fail_count   = 0;
  int           idle_cycles  = 0;

  recursive_lock_table_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .lock_index_i  (lock_index_i),
    .thread_id_i   (thread_id_i),
    .count_value_i (count_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .hold_count_o  (hold_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one request to the lock table and return its result
  function automatic lock_result_t apply_request(lock_request_t rq);
    lock_result_t r;
    logic         mine;
    r.status = rlt_pkg::ST_OK;
    r.hold   = '0;
    mine     = tbl_held[rq.idx] && (tbl_owner[rq.idx] == rq.tid);
    case (rq.op)
      rlt_pkg::OP_ACQUIRE: begin
        if (!tbl_held[rq.idx]) begin
          tbl_held[rq.idx]  = 1'b1;
          tbl_owner[rq.idx] = rq.tid;
          tbl_count[rq.idx] = 32'd1;
        end else if (mine) begin
          if (&tbl_count[rq.idx]) r.status = rlt_pkg::ST_OVERFLOW;
          else tbl_count[rq.idx] = tbl_count[rq.idx] + 32'd1;
        end else begin
          r.status = rlt_pkg::ST_BUSY;
        end
      end
      rlt_pkg::OP_REACQUIRE: begin
        if (!tbl_held[rq.idx]) begin
          tbl_held[rq.idx]  = 1'b1;
          tbl_owner[rq.idx] = rq.tid;
          tbl_count[rq.idx] = rq.cnt;
        end else if (mine) begin
          r.status = rlt_pkg::ST_ILLEGAL;
        end else begin
          r.status = rlt_pkg::ST_BUSY;
        end
      end
      rlt_pkg::OP_RELEASE: begin
        if (!mine || tbl_count[rq.idx] == '0) begin
          r.status = rlt_pkg::ST_NOT_OWNER;
        end else begin
          tbl_count[rq.idx] = tbl_count[rq.idx] - 32'd1;
          if (tbl_count[rq.idx] == '0) begin
            tbl_held[rq.idx]  = 1'b0;
            tbl_owner[rq.idx] = '0;
          end
        end
      end
      rlt_pkg::OP_RELEASE_ALL: begin
        if (!mine || tbl_count[rq.idx] == '0) begin
          r.status = rlt_pkg::ST_NOT_OWNER;
        end else begin
          r.hold            = tbl_count[rq.idx];
          tbl_count[rq.idx] = '0;
          tbl_held[rq.idx]  = 1'b0;
          tbl_owner[rq.idx] = '0;
        end
      end
      rlt_pkg::OP_QUERY: begin
        if (mine) r.hold = tbl_count[rq.idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  // random request, biased toward a few hot locks and their owners
  function automatic lock_request_t random_request();
    lock_request_t rq;
    int            pick;
    if ($urandom_range(99) < 80) rq.idx = 6'($urandom_range(7)) ^ hot_mask;
    else rq.idx = 6'($urandom_range(LOCKS - 1));
    pick = $urandom_range(99);
    if (tbl_held[rq.idx] && pick < 60) rq.tid = tbl_owner[rq.idx];
    else if (pick < 95) rq.tid = tid_pool[$urandom_range(3)];
    else rq.tid = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) rq.op = rlt_pkg::OP_ACQUIRE;
    else if (pick < 40) rq.op = rlt_pkg::OP_REACQUIRE;
    else if (pick < 65) rq.op = rlt_pkg::OP_RELEASE;
    else if (pick < 75) rq.op = rlt_pkg::OP_RELEASE_ALL;
    else if (pick < 94) rq.op = rlt_pkg::OP_QUERY;
    else rq.op = OP_RSVD_LO + 3'($urandom_range(OP_RSVD_HI - OP_RSVD_LO));
    // restored counts: half small, the rest zero, random or near the top
    case ($urandom_range(5))
      0: rq.cnt = '0;
      1: rq.cnt = 32'hFFFF_FFFF - 32'($urandom_range(1));
      2: rq.cnt = $urandom;
      default: rq.cnt = 32'($urandom_range(1, 4));
    endcase
    return rq;
  endfunction

  function automatic stim_row_t mk_row(logic [rlt_pkg::OP_W-1:0] op,
                                       logic [rlt_pkg::IDX_W-1:0] idx,
                                       logic [rlt_pkg::TID_W-1:0] tid,
                                       logic [rlt_pkg::COUNT_W-1:0] cnt,
                                       bit typed, rlt_pkg::status_e st,
                                       logic [rlt_pkg::COUNT_W-1:0] hold);
    stim_row_t row;
    row.req    = '{op: op, idx: idx, tid: tid, cnt: cnt};
    row.typed  = typed;
    row.res    = '{status: st, hold: hold};
    return row;
  endfunction

  // request side: predict on acceptance, then put up the next item
  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        res = apply_request(cur_row.req);
        pending_results.push_back(cur_row.typed ? cur_row.res : res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (to_issue > 0 && $urandom_range(99) >= src_idle_pct) begin
          if (from_table) begin
            cur_row = directed_rows.pop_front();
          end else begin
            cur_row.req   = random_request();
            cur_row.typed = MODELED;
          end
          to_issue      = to_issue - 1;
          in_valid_i    <= 1'b1;
          operation_i   <= cur_row.req.op;
          lock_index_i  <= cur_row.req.idx;
          thread_id_i   <= cur_row.req.tid;
          count_value_i <= cur_row.req.cnt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side: random stall, in-order check
  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("unexpected result: status %0d hold %h", status_o, hold_count_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status || hold_count_o !== want.hold) begin
            if (fail_count < REPORT_MAX)
              $display("mismatch: status exp %0d got %0d, hold exp %h got %h",
                       want.status, status_o, want.hold, hold_count_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("FAIL recursive_lock_table_top");
        $finish;
      end
    end
  end

  // one phase of traffic, then hold off until every result is back
  task automatic run_phase(bit use_table, int n, int src_pct, int snk_pct);
    @(negedge clk_i);
    hot_mask = 6'($urandom);
    foreach (tid_pool[k]) tid_pool[k] = 16'($urandom);
    from_table   = use_table;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    to_issue     = n;
    while (to_issue != 0 || in_valid_i) @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // sequencer
  initial begin
    foreach (tbl_held[k]) begin
      tbl_held[k]  = 1'b0;
      tbl_owner[k] = '0;
      tbl_count[k] = '0;
    end

    // reset state, owner recursion, contention
    directed_rows.push_back(mk_row(rlt_pkg::OP_QUERY, 6'd0, 16'h0000, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd0, 16'hFFFF, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd0, 16'hFFFF, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_QUERY, 6'd0, 16'hFFFF, '0, TYPED,
                                   rlt_pkg::ST_OK, 32'd2));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd0, 16'h0000, '0, TYPED,
                                   rlt_pkg::ST_BUSY, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_REACQUIRE, 6'd0, 16'hFFFF, 32'd5, TYPED,
                                   rlt_pkg::ST_ILLEGAL, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_REACQUIRE, 6'd0, 16'h0001, 32'd5, TYPED,
                                   rlt_pkg::ST_BUSY, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE, 6'd0, 16'h0001, '0, TYPED,
                                   rlt_pkg::ST_NOT_OWNER, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE_ALL, 6'd0, 16'hFFFF, '0, TYPED,
                                   rlt_pkg::ST_OK, 32'd2));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE, 6'd0, 16'hFFFF, '0, TYPED,
                                   rlt_pkg::ST_NOT_OWNER, '0));
    // count at its maximum: acquire overflows
    directed_rows.push_back(mk_row(rlt_pkg::OP_REACQUIRE, 6'd63, 16'h1234, 32'hFFFF_FFFF,
                                   TYPED, rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd63, 16'h1234, '0, TYPED,
                                   rlt_pkg::ST_OVERFLOW, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_QUERY, 6'd63, 16'h1234, '0, TYPED,
                                   rlt_pkg::ST_OK, 32'hFFFF_FFFF));
    directed_rows.push_back(mk_row(rlt_pkg::OP_QUERY, 6'd63, 16'h1235, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE, 6'd63, 16'h1234, '0, MODELED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE_ALL, 6'd63, 16'h1234, '0, MODELED,
                                   rlt_pkg::ST_OK, '0));
    // lock held at count zero
    directed_rows.push_back(mk_row(rlt_pkg::OP_REACQUIRE, 6'd21, 16'h5555, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE, 6'd21, 16'h5555, '0, TYPED,
                                   rlt_pkg::ST_NOT_OWNER, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE_ALL, 6'd21, 16'h5555, '0, TYPED,
                                   rlt_pkg::ST_NOT_OWNER, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_QUERY, 6'd21, 16'h5555, '0, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd21, 16'hAAAA, '0, TYPED,
                                   rlt_pkg::ST_BUSY, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_ACQUIRE, 6'd21, 16'h5555, '0, MODELED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(rlt_pkg::OP_RELEASE, 6'd21, 16'h5555, '0, MODELED,
                                   rlt_pkg::ST_OK, '0));
    // unused operation codes
    directed_rows.push_back(mk_row(OP_RSVD_LO, 6'd42, 16'hAAAA, 32'hAAAA_AAAA, TYPED,
                                   rlt_pkg::ST_OK, '0));
    directed_rows.push_back(mk_row(OP_RSVD_HI, 6'd42, 16'h5555, 32'h5555_5555, TYPED,
                                   rlt_pkg::ST_OK, '0));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    run_phase(1'b1, directed_rows.size(), 31, 46);
    run_phase(1'b0, RANDOM_ITEMS, 31, 46);
    run_phase(1'b0, RANDOM_ITEMS, 46, 31);
    run_phase(1'b0, RANDOM_ITEMS, 0, 0);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS recursive_lock_table_top");
    end else begin
      $display("FAIL recursive_lock_table_top");
    end
    $finish;
  end

endmodule
